[src/midi_pkg.sv]
// Types and codes shared by the MIDI message parser.
`timescale 1ns / 1ps

package midi_pkg;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_NOTE_ON    = 4'd1,
    EV_NOTE_OFF   = 4'd2,
    EV_POLY       = 4'd3,
    EV_CC         = 4'd4,
    EV_PROGRAM    = 4'd5,
    EV_PRESSURE   = 4'd6,
    EV_BEND       = 4'd7,
    EV_SYX_BYTE   = 4'd8,
    EV_SYX_END    = 4'd9,
    EV_INVALID    = 4'd10,
    EV_UNFINISHED = 4'd11
  } event_kind_t;

  typedef enum logic [2:0] {
    K_NOTE_OFF = 3'd0,
    K_NOTE_ON  = 3'd1,
    K_POLY     = 3'd2,
    K_CC       = 3'd3,
    K_PROGRAM  = 3'd4,
    K_PRESSURE = 3'd5,
    K_BEND     = 3'd6,
    K_SYSEX    = 3'd7
  } msg_kind_t;

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_DATA1 = 2'd1,
    PH_DATA2 = 2'd2
  } rx_phase_t;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [3:0] SYSTEM_NIB  = 4'hF;

endpackage

[src/midi_message_parser_unit.sv]
// MIDI receive parser: turns each received byte into one event word.
`timescale 1ns / 1ps

// Each accepted byte produces exactly one event word in the following cycle, and a
// new byte is taken in every cycle that the output register is empty or being
// drained, so the sustained rate is one byte per clock. The only loop is the
// parser state (channel, message kind, receive phase, first data byte), which
// is updated in the same cycle that a byte is accepted. There is no running
// status: stray data bytes report EV_INVALID, and F7 does not close a SysEx.
module midi_message_parser_unit
  import midi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_kind,
  output logic [3:0]  channel,
  output logic [6:0]  number,
  output logic [13:0] value
);

  logic [3:0]  chan_reg;
  msg_kind_t   msg_kind;
  rx_phase_t   rx_phase;
  logic [6:0]  first_data;

  logic [3:0]  chan_reg_next;
  msg_kind_t   msg_kind_next;
  rx_phase_t   rx_phase_next;
  logic [6:0]  first_data_next;

  event_kind_t ev;
  logic [6:0]  ev_number;
  logic [13:0] ev_value;

  logic [6:0]  data;
  logic        is_system;
  logic        is_status;
  logic        accept;

  assign data      = rx_byte[6:0];
  assign is_system = (rx_byte[7:4] == SYSTEM_NIB);
  assign is_status = rx_byte[7] && !is_system;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    chan_reg_next   = chan_reg;
    msg_kind_next   = msg_kind;
    rx_phase_next   = rx_phase;
    first_data_next = first_data;
    if (is_system) begin
      if (rx_byte == SYSEX_START) begin
        msg_kind_next = K_SYSEX;
      end
    end else if (is_status) begin
      chan_reg_next = rx_byte[3:0];
      msg_kind_next = msg_kind_t'(rx_byte[6:4]);
      rx_phase_next = PH_DATA1;
    end else if (msg_kind == K_SYSEX) begin
      rx_phase_next = rx_phase;
    end else if (msg_kind == K_PROGRAM || msg_kind == K_PRESSURE) begin
      if (rx_phase == PH_DATA1) begin
        rx_phase_next = PH_READY;
      end
    end else if (rx_phase == PH_DATA1) begin
      first_data_next = data;
      rx_phase_next   = PH_DATA2;
    end else if (rx_phase == PH_DATA2) begin
      rx_phase_next = PH_READY;
    end
  end

  always_comb begin
    ev        = EV_NONE;
    ev_number = '0;
    ev_value  = '0;
    if (is_system) begin
      if (rx_byte == SYSEX_END) begin
        ev = EV_SYX_END;
      end
    end else if (is_status) begin
      if (rx_phase != PH_READY) begin
        ev = EV_UNFINISHED;
      end
    end else if (msg_kind == K_SYSEX) begin
      ev       = EV_SYX_BYTE;
      ev_value = {7'd0, data};
    end else if (msg_kind == K_PROGRAM || msg_kind == K_PRESSURE) begin
      if (rx_phase == PH_DATA1) begin
        ev       = (msg_kind == K_PROGRAM) ? EV_PROGRAM : EV_PRESSURE;
        ev_value = {7'd0, data};
      end else begin
        ev = EV_INVALID;
      end
    end else if (rx_phase == PH_DATA1) begin
      ev = EV_NONE;
    end else if (rx_phase != PH_DATA2) begin
      ev = EV_INVALID;
    end else begin
      ev_number = first_data;
      ev_value  = {7'd0, data};
      case (msg_kind)
        K_NOTE_ON:  ev = (data != 7'd0) ? EV_NOTE_ON : EV_NOTE_OFF;
        K_NOTE_OFF: ev = EV_NOTE_OFF;
        K_POLY:     ev = EV_POLY;
        K_CC:       ev = EV_CC;
        default: begin
          ev        = EV_BEND;
          ev_number = '0;
          ev_value  = {data, first_data};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_reg   <= '0;
      msg_kind   <= K_NOTE_OFF;
      rx_phase   <= PH_READY;
      first_data <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        chan_reg   <= chan_reg_next;
        msg_kind   <= msg_kind_next;
        rx_phase   <= rx_phase_next;
        first_data <= first_data_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_kind <= ev;
      channel    <= (ev == EV_NONE) ? 4'd0 : chan_reg;
      number     <= ev_number;
      value      <= ev_value;
    end
  end

`ifndef SYNTH
  a_status_opens: assert property (@(posedge clk) disable iff (rst)
    accept && rx_byte[7] && (rx_byte[7:4] != SYSTEM_NIB) |=> rx_phase == PH_DATA1)
    else $error("channel status byte did not open a message");

  a_none_no_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_NONE) |-> (channel == 4'd0) && (value == 14'd0))
    else $error("empty event carries channel or value");

  a_number_kinds: assert property (@(posedge clk) disable iff (rst)
    out_valid && (number != 7'd0) |->
      (event_kind == EV_NOTE_ON) || (event_kind == EV_NOTE_OFF) ||
      (event_kind == EV_POLY) || (event_kind == EV_CC))
    else $error("number set on an event kind that has none");

  a_free_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");
`endif

endmodule
